>>> rtl/alrp_pkg.sv
`timescale 1ns / 1ps

package alrp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_UNIT   = 3'd0,
    CFG_UNITS_PER_STEP   = 3'd1,
    CFG_BRIGHTNESS_STEP  = 3'd2,
    CFG_PWM_PERIOD       = 3'd3,
    CFG_BRIGHTNESS_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    REQ_SLOW_TICK = 1'b0,
    REQ_PWM_TICK  = 1'b1
  } req_type_e;

  localparam logic [7:0]  TicksPerUnitRst    = 8'd6;
  localparam logic [15:0] UnitsPerStepRst    = 16'd128;
  localparam logic [7:0]  BrightnessStepRst  = 8'd1;
  localparam logic [7:0]  PwmPeriodRst       = 8'd10;
  localparam logic [7:0]  BrightnessLimitRst = 8'd12;

  typedef struct packed {
    logic [7:0] brightness_level;
    logic       alarm_active;
    logic       led_out;
  } result_t;

endpackage

>>> rtl/alarm_light_ramp_pwm.sv
`timescale 1ns / 1ps

// Sunrise-alarm LED dimmer.
// Slave channel: one request per tick. tuser selects a slow timer tick
// (carrying alarm and button pin samples in tdata) or a PWM tick.
// Master channel: one result per request with the LED drive, the latched
// alarm flag and the current brightness.
// Configuration: write enable, register index and data; the user must write only
// while the block is idle, which the block does not enforce. Unknown indexes are ignored.
// The state is updated and the result registered at the edge that accepts
// the request. Throughput is one request per clock while the receiver does
// not stall, set by the single output register.
// When the receiver stalls, the output register holds its result and
// s_axis_tready follows m_axis_tready, so no result is lost or repeated.
// Reset clears all counters, the alarm and the brightness, restores the
// register defaults and leaves the output channel empty.
module alarm_light_ramp_pwm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [alrp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [alrp_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // alarm_in, button_in, zeros
  input  logic                              s_axis_tuser,  // req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata   // led_out, alarm_active,
                                                           // brightness_level, zeros
);

  logic [7:0]  ticks_per_unit_q, brightness_step_q, pwm_period_q, brightness_limit_q;
  logic [15:0] units_per_step_q;

  logic [7:0]  prescale_q, prescale_d;
  logic [15:0] unit_q, unit_d;
  logic        pending_q, pending_d;
  logic        prev_alarm_q, prev_alarm_d;
  logic        prev_button_q, prev_button_d;
  logic        alarm_on_q, alarm_on_d;
  logic [7:0]  bright_q, bright_d;
  logic [7:0]  pwm_cnt_q, pwm_cnt_d;
  logic        led_q, led_d;

  logic                  out_valid_q;
  alrp_pkg::result_t     out_q;

  logic       accept;
  logic       a_in, b_in;
  logic [7:0] pre_inc, pwm_inc;
  logic [8:0] bright_sum;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign a_in          = s_axis_tdata[0];
  assign b_in          = s_axis_tdata[1];
  assign pre_inc       = prescale_q + 8'd1;
  assign pwm_inc       = pwm_cnt_q + 8'd1;

  always_comb begin
    prescale_d    = prescale_q;
    unit_d        = unit_q;
    pending_d     = pending_q;
    prev_alarm_d  = prev_alarm_q;
    prev_button_d = prev_button_q;
    alarm_on_d    = alarm_on_q;
    bright_d      = bright_q;
    pwm_cnt_d     = pwm_cnt_q;
    led_d         = led_q;
    bright_sum    = {1'b0, bright_q} + {1'b0, brightness_step_q};
    if (alrp_pkg::req_type_e'(s_axis_tuser) == alrp_pkg::REQ_SLOW_TICK) begin
      prescale_d = pre_inc;
      if (pre_inc >= ticks_per_unit_q) begin
        prescale_d = 8'd0;
        unit_d     = unit_q + 16'd1;
      end
      if (unit_d >= units_per_step_q) begin
        unit_d    = 16'd0;
        pending_d = 1'b1;
      end
      if (a_in && prev_alarm_q) begin
        alarm_on_d = 1'b1;
      end
      prev_alarm_d  = a_in;
      prev_button_d = b_in;
      if (b_in && prev_button_q) begin
        bright_d   = 8'd0;
        alarm_on_d = 1'b0;
      end
      if (pending_d && alarm_on_d) begin
        pending_d = 1'b0;
        if (bright_q < brightness_limit_q) begin
          bright_d = bright_sum[8] ? 8'hff : bright_sum[7:0];
        end
      end
    end else if (alarm_on_q) begin
      pwm_cnt_d = pwm_inc;
      if (pwm_inc >= bright_q) begin
        led_d = 1'b0;
      end
      if (pwm_inc >= pwm_period_q) begin
        pwm_cnt_d = 8'd0;
        led_d     = 1'b1;
      end
    end
    if (!alarm_on_d) begin
      led_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_unit_q   <= alrp_pkg::TicksPerUnitRst;
      units_per_step_q   <= alrp_pkg::UnitsPerStepRst;
      brightness_step_q  <= alrp_pkg::BrightnessStepRst;
      pwm_period_q       <= alrp_pkg::PwmPeriodRst;
      brightness_limit_q <= alrp_pkg::BrightnessLimitRst;
    end else if (cfg_we_i) begin
      case (alrp_pkg::cfg_idx_e'(cfg_idx_i))
        alrp_pkg::CFG_TICKS_PER_UNIT:   ticks_per_unit_q   <= cfg_wdata_i[7:0];
        alrp_pkg::CFG_UNITS_PER_STEP:   units_per_step_q   <= cfg_wdata_i;
        alrp_pkg::CFG_BRIGHTNESS_STEP:  brightness_step_q  <= cfg_wdata_i[7:0];
        alrp_pkg::CFG_PWM_PERIOD:       pwm_period_q       <= cfg_wdata_i[7:0];
        alrp_pkg::CFG_BRIGHTNESS_LIMIT: brightness_limit_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q    <= 8'd0;
      unit_q        <= 16'd0;
      pending_q     <= 1'b0;
      prev_alarm_q  <= 1'b0;
      prev_button_q <= 1'b1;
      alarm_on_q    <= 1'b0;
      bright_q      <= 8'd0;
      pwm_cnt_q     <= 8'd0;
      led_q         <= 1'b0;
    end else if (accept) begin
      prescale_q    <= prescale_d;
      unit_q        <= unit_d;
      pending_q     <= pending_d;
      prev_alarm_q  <= prev_alarm_d;
      prev_button_q <= prev_button_d;
      alarm_on_q    <= alarm_on_d;
      bright_q      <= bright_d;
      pwm_cnt_q     <= pwm_cnt_d;
      led_q         <= led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.led_out          <= led_d;
      out_q.alarm_active     <= alarm_on_d;
      out_q.brightness_level <= bright_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

endmodule

>>> bench/alarm_light_ramp_pwm_tb.sv
`timescale 1ns / 1ps

module alarm_light_ramp_pwm_tb;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned PrintLimit  = 100;
  localparam int unsigned PhaseItems  = 135;
  localparam int unsigned NumPhases   = 8;

  // Predicts the light state for each accepted tick and holds the
  // results still owed by the block, oldest first.
  class dimmer_scoreboard;
    logic [7:0]  ticks_per_unit, brightness_step, pwm_period, brightness_limit;
    logic [15:0] units_per_step;
    logic [7:0]  prescale_count, brightness, pwm_count;
    logic [15:0] unit_count;
    bit          step_pending, prev_alarm, prev_button, alarm_on, led_level;
    alrp_pkg::result_t light_q[$];

    function new();
      ticks_per_unit   = alrp_pkg::TicksPerUnitRst;
      units_per_step   = alrp_pkg::UnitsPerStepRst;
      brightness_step  = alrp_pkg::BrightnessStepRst;
      pwm_period       = alrp_pkg::PwmPeriodRst;
      brightness_limit = alrp_pkg::BrightnessLimitRst;
      prescale_count   = '0;
      unit_count       = '0;
      brightness       = '0;
      pwm_count        = '0;
      step_pending     = 1'b0;
      prev_alarm       = 1'b0;
      prev_button      = 1'b1;
      alarm_on         = 1'b0;
      led_level        = 1'b0;
    endfunction

    function void write_reg(logic [alrp_pkg::CfgIdxW-1:0] idx,
                            logic [alrp_pkg::CfgDataW-1:0] data);
      case (idx)
        alrp_pkg::CFG_TICKS_PER_UNIT:   ticks_per_unit   = data[7:0];
        alrp_pkg::CFG_UNITS_PER_STEP:   units_per_step   = data;
        alrp_pkg::CFG_BRIGHTNESS_STEP:  brightness_step  = data[7:0];
        alrp_pkg::CFG_PWM_PERIOD:       pwm_period       = data[7:0];
        alrp_pkg::CFG_BRIGHTNESS_LIMIT: brightness_limit = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_tick(alrp_pkg::req_type_e kind, bit alarm_pin, bit button_pin);
      bit                shutoff;
      int unsigned       sum;
      alrp_pkg::result_t res;
      if (kind == alrp_pkg::REQ_SLOW_TICK) begin
        prescale_count = prescale_count + 8'd1;
        if (prescale_count >= ticks_per_unit) begin
          prescale_count = '0;
          unit_count     = unit_count + 16'd1;
        end
        if (unit_count >= units_per_step) begin
          unit_count   = '0;
          step_pending = 1'b1;
        end
        if (alarm_pin && prev_alarm) alarm_on = 1'b1;
        prev_alarm  = alarm_pin;
        shutoff     = prev_button && button_pin;
        prev_button = button_pin;
        // shutoff wins and keeps a pending step
        if (shutoff) begin
          brightness = '0;
          alarm_on   = 1'b0;
        end
        if (step_pending && alarm_on) begin
          step_pending = 1'b0;
          if (brightness < brightness_limit) begin
            sum        = brightness + brightness_step;
            brightness = (sum > 255) ? 8'd255 : sum[7:0];
          end
        end
      end else if (alarm_on) begin
        pwm_count = pwm_count + 8'd1;
        if (pwm_count >= brightness) led_level = 1'b0;
        if (pwm_count >= pwm_period) begin
          pwm_count = '0;
          led_level = 1'b1;
        end
      end
      if (!alarm_on) led_level = 1'b0;
      res.led_out          = led_level;
      res.alarm_active     = alarm_on;
      res.brightness_level = brightness;
      light_q.push_back(res);
    endfunction

    function string check_result(logic [15:0] data);
      alrp_pkg::result_t got, want;
      string             msg;
      got = data[9:0];
      if (light_q.size() == 0) return $sformatf("result %h with nothing expected", data);
      want = light_q.pop_front();
      msg  = "";
      if (got.led_out !== want.led_out)
        msg = {msg, $sformatf(" led_out %b exp %b", got.led_out, want.led_out)};
      if (got.alarm_active !== want.alarm_active)
        msg = {msg, $sformatf(" alarm_active %b exp %b", got.alarm_active, want.alarm_active)};
      if (got.brightness_level !== want.brightness_level)
        msg = {msg, $sformatf(" brightness_level %0d exp %0d",
                              got.brightness_level, want.brightness_level)};
      return msg;
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [alrp_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [alrp_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;   // alarm_in, button_in, zeros
  logic                          s_axis_tuser;   // req_type
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;   // led_out, alarm_active,
                                                 // brightness_level, zeros

  logic [15:0] fix_ticks[5]  = '{16'd1, 16'd0, 16'd255, 16'd2, 16'd1};
  logic [15:0] fix_units[5]  = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd0};
  logic [15:0] fix_step[5]   = '{16'd1, 16'd255, 16'd7, 16'd16, 16'd3};
  logic [15:0] fix_period[5] = '{16'd10, 16'd0, 16'd255, 16'd20, 16'd3};
  logic [15:0] fix_limit[5]  = '{16'd255, 16'd0, 16'd12, 16'd200, 16'd255};

  dimmer_scoreboard sb;
  int unsigned      mismatches  = 0;
  int unsigned      idle_cycles = 0;
  bit               calm_stretch = 1'b0;
  string            check_msg;

  alarm_light_ramp_pwm u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PrintLimit) $display("%0t mismatch:%s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm_stretch ? 1'b1 : ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_msg = sb.check_result(m_axis_tdata);
      if (check_msg != "") report_mismatch(check_msg);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(alrp_pkg::req_type_e kind, bit alarm_pin, bit button_pin);
    if (!calm_stretch) begin
      while ($urandom_range(0, 99) < 16) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'b0, button_pin, alarm_pin};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(kind, alarm_pin, button_pin);
  endtask

  task automatic write_cfg(logic [alrp_pkg::CfgIdxW-1:0] idx,
                           logic [alrp_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(logic [15:0] ticks, logic [15:0] units, logic [15:0] step,
                                logic [15:0] period, logic [15:0] limit);
    write_cfg(alrp_pkg::CFG_TICKS_PER_UNIT, ticks);
    write_cfg(alrp_pkg::CFG_UNITS_PER_STEP, units);
    write_cfg(alrp_pkg::CFG_BRIGHTNESS_STEP, step);
    write_cfg(alrp_pkg::CFG_PWM_PERIOD, period);
    write_cfg(alrp_pkg::CFG_BRIGHTNESS_LIMIT, limit);
    // unused index, must be ignored
    write_cfg(alrp_pkg::CfgIdxW'($urandom_range(5, 7)),
              alrp_pkg::CfgDataW'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
  endtask

  // drain all owed results before touching the registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.light_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned n_items);
    int unsigned i, roll;
    i = 0;
    while (i < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_tick(alrp_pkg::req_type_e'($urandom_range(0, 1)), $urandom_range(0, 1),
                  $urandom_range(0, 1));
        i += 1;
      end else if (roll < 13) begin
        // deliberate button press: two highs in a row
        send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b1, 1'b1);
        send_tick(alrp_pkg::REQ_SLOW_TICK, $urandom_range(0, 1), 1'b1);
        i += 2;
      end else if (roll < 55) begin
        send_tick(alrp_pkg::REQ_PWM_TICK, $urandom_range(0, 1), $urandom_range(0, 1));
        i += 1;
      end else begin
        send_tick(alrp_pkg::REQ_SLOW_TICK, $urandom_range(0, 99) < 90,
                  $urandom_range(0, 99) < 4);
        i += 1;
      end
    end
  endtask

  initial begin
    logic [7:0] junk;

    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= alrp_pkg::REQ_SLOW_TICK;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: shutoff straight out of reset, alarm off PWM, debounce
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b0, 1'b1);
    send_tick(alrp_pkg::REQ_PWM_TICK, 1'b1, 1'b1);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b1, 1'b0);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b1, 1'b0);
    repeat (4) send_tick(alrp_pkg::REQ_PWM_TICK, 1'b0, 1'b0);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b1, 1'b1);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b0, 1'b1);
    settle();

    // zero prescaler, zero units, zero period, saturating ramp
    apply_settings(16'd0, 16'd0, 16'd200, 16'd0, 16'd255);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b1, 1'b0);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b1, 1'b0);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b1, 1'b0);
    send_tick(alrp_pkg::REQ_PWM_TICK, 1'b0, 1'b0);
    send_tick(alrp_pkg::REQ_PWM_TICK, 1'b1, 1'b1);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b0, 1'b0);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b0, 1'b1);
    send_tick(alrp_pkg::REQ_SLOW_TICK, 1'b0, 1'b1);
    send_tick(alrp_pkg::REQ_PWM_TICK, 1'b0, 1'b0);
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p < 5) begin
        apply_settings(fix_ticks[p], fix_units[p], fix_step[p], fix_period[p], fix_limit[p]);
      end else begin
        junk = $urandom_range(0, 255);
        apply_settings({junk, 8'($urandom_range(0, 4))},
                       16'($urandom_range(0, 6)),
                       {~junk, 8'($urandom_range(1, 255))},
                       {junk, 8'($urandom_range(0, 40))},
                       {~junk, 8'($urandom_range(0, 255))});
      end
      calm_stretch = (p == 3);
      run_phase(PhaseItems);
      settle();
      calm_stretch = 1'b0;
    end

    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/alrp_pkg.sv
rtl/alarm_light_ramp_pwm.sv
bench/alarm_light_ramp_pwm_tb.sv
